@@ rtl/vpd_pkg.sv @@
// vpd_pkg: shared types and constants for the varint packet deframer
// result item layout and kind codes; no dependencies
`timescale 1ns / 1ps

package vpd_pkg;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [7:0] VARINT_DATA_MASK = 8'b0111_1111;
	localparam logic [7:0] VARINT_MORE_BIT  = 8'b1000_0000;
	localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] frame_length;
		logic [31:0] pkt_id;
		logic [7:0]  payload_byte;
		logic        last_of_packet;
	} result_t;

endpackage

@@ rtl/vpd_core.sv @@
// vpd_core: deframer state and per-byte update logic
// consumes one byte per enable, gives at most one result; uses vpd_pkg
`timescale 1ns / 1ps

module vpd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        in_byte,
	output logic              res_valid,
	output vpd_pkg::result_t  res
);

	typedef enum logic [1:0] {
		PH_LENGTH  = 2'd0,
		PH_ID      = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [31:0] len_q, len_d;
	logic [31:0] id_q, id_d;
	logic [31:0] rem_q, rem_d;

	logic [6:0]  grp_bits;
	logic [31:0] grp;
	logic [31:0] acc_new;
	logic [2:0]  cnt_new;
	logic [31:0] rem_dec;
	logic [31:0] rem_new;

	assign grp_bits = in_byte[6:0] & vpd_pkg::VARINT_DATA_MASK[6:0];

	// place the 7-bit group at its position, bits above 31 dropped
	always_comb begin
		unique case (cnt_q)
			3'd0:    grp = {25'b0, grp_bits};
			3'd1:    grp = {18'b0, grp_bits, 7'b0};
			3'd2:    grp = {11'b0, grp_bits, 14'b0};
			3'd3:    grp = {4'b0, grp_bits, 21'b0};
			3'd4:    grp = {grp_bits[3:0], 28'b0};
			default: grp = 32'b0;
		endcase
	end

	assign acc_new = acc_q | grp;
	assign cnt_new = cnt_q + 3'd1;
	assign rem_dec = rem_q - 32'd1;
	assign rem_new = len_q - {29'b0, cnt_new};

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		len_d     = len_q;
		id_d      = id_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res       = '{kind: vpd_pkg::KIND_ERROR, frame_length: 32'b0, pkt_id: 32'b0,
			payload_byte: 8'b0, last_of_packet: 1'b1};
		if (phase_q == PH_PAYLOAD) begin
			rem_d     = rem_dec;
			res_valid = 1'b1;
			res       = '{kind: vpd_pkg::KIND_PAYLOAD, frame_length: len_q,
				pkt_id: id_q, payload_byte: in_byte,
				last_of_packet: (rem_dec == 32'b0)};
			if (rem_dec == 32'b0) begin
				phase_d = PH_LENGTH;
			end
		end else if (cnt_q >= vpd_pkg::VARINT_MAX_BYTES) begin
			// overlong varint
			res_valid = 1'b1;
			res.frame_length = (phase_q == PH_ID) ? len_q : 32'b0;
			acc_d   = 32'b0;
			cnt_d   = 3'd0;
			phase_d = PH_LENGTH;
		end else begin
			acc_d = acc_new;
			cnt_d = cnt_new;
			if ((in_byte & vpd_pkg::VARINT_MORE_BIT) != 8'b0) begin
				// more groups follow
			end else if (phase_q != PH_ID) begin
				len_d   = acc_new;
				acc_d   = 32'b0;
				cnt_d   = 3'd0;
				phase_d = PH_ID;
			end else begin
				id_d    = acc_new;
				acc_d   = 32'b0;
				cnt_d   = 3'd0;
				rem_d   = rem_new;
				res.frame_length = len_q;
				res.pkt_id       = acc_new;
				if (len_q < {29'b0, cnt_new}) begin
					res_valid = 1'b1;
					phase_d   = PH_LENGTH;
				end else if (rem_new == 32'b0) begin
					res_valid = 1'b1;
					res.kind  = vpd_pkg::KIND_HEADER;
					phase_d   = PH_LENGTH;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LENGTH;
			acc_q   <= 32'b0;
			cnt_q   <= 3'd0;
			len_q   <= 32'b0;
			id_q    <= 32'b0;
			rem_q   <= 32'b0;
		end else if (en) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			id_q    <= id_d;
			rem_q   <= rem_d;
		end
	end

	// varint byte count never passes the limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= vpd_pkg::VARINT_MAX_BYTES)
		else $error("varint byte count overflow");

	// payload phase never entered with nothing left
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != 32'b0)
		else $error("payload phase with zero remaining");

	// only payload results carry a byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && res_valid && res.kind != vpd_pkg::KIND_PAYLOAD |->
		res.payload_byte == 8'b0 && res.last_of_packet)
		else $error("non-payload result with byte or without last");

	// header-only and error results always return to length decoding
	a_back_to_length: assert property (@(posedge clk) disable iff (!arst_n)
		en && res_valid && res.kind != vpd_pkg::KIND_PAYLOAD |=>
		phase_q == PH_LENGTH && cnt_q == 3'd0)
		else $error("no resync after header or error");

endmodule

@@ rtl/varint_packet_deframer_unit.sv @@
// varint_packet_deframer_unit: top level, input register, core, result register
// depends on vpd_pkg and vpd_core
`timescale 1ns / 1ps

// path: an accepted byte waits in the input register; the core decodes it and its result is registered onto m_axis
// throughput: one byte per cycle; the input side stalls only while a result
// waits on m_axis and a byte is already held in the input register
// reset: arst_n clears valid flags and the parser state (expect a length)

module varint_packet_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // frame_length, pkt_id, payload_byte
	output logic        m_axis_tlast,  // last_of_packet
	output logic [1:0]  m_axis_tuser   // kind
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             core_valid;
	vpd_pkg::result_t core_res;
	logic             out_valid_q;
	vpd_pkg::result_t out_res_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	vpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_byte   (byte_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= advance && core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			out_res_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_res_q.payload_byte, out_res_q.pkt_id,
		out_res_q.frame_length};
	assign m_axis_tlast  = out_res_q.last_of_packet;
	assign m_axis_tuser  = out_res_q.kind;

	// input side stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// a result that is never produced cannot show up
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!advance && !out_valid_q |=> !m_axis_tvalid)
		else $error("result appeared without a processed item");

	// result kind is always a defined code
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser == vpd_pkg::KIND_PAYLOAD ||
		m_axis_tuser == vpd_pkg::KIND_HEADER || m_axis_tuser == vpd_pkg::KIND_ERROR)
		else $error("undefined result kind");

endmodule
